/* src/dts_pkg.sv */
// Shared types, codes and timing helpers for the deadline task scheduler.
// No dependencies; imported by every other source and test file.

package dts_pkg;

  // Half of the 32-bit time range, the limit of the wrap-safe compares.
  localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

  // Widths of the stream words.
  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 2;

  // Operation codes carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ONE_SHOT = 2'd1,
    OP_PERIODIC = 2'd2
  } op_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  // One row of the task memory.
  typedef struct packed {
    logic [7:0]  id;
    logic        one_shot;
    logic [31:0] period;
    logic [31:0] deadline;
  } entry_t;

  // True when cand lies strictly before best, allowing for wrap.
  function automatic logic is_earlier(input logic [31:0] cand, input logic [31:0] best);
    logic [31:0] d;
    d = best - cand;
    return (d != 32'd0) && (d <= HALF_RANGE);
  endfunction

  // True when the deadline has passed at time now. Just past half range in the
  // future still counts as elapsed, matching the unsigned test on both sides.
  function automatic logic has_elapsed(input logic [31:0] deadline, input logic [31:0] now);
    logic [31:0] d;
    d = now - deadline;
    return (d <= HALF_RANGE) ||
           ((now < deadline) &&
            ((d == HALF_RANGE + 32'd1) || (d == HALF_RANGE + 32'd2)));
  endfunction

endpackage

/* src/dts_entry_ram.sv */
// Task table storage: single write port, single registered read port.
// Depends on dts_pkg for the entry_t row layout.

module dts_entry_ram
  import dts_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/deadline_task_scheduler.sv */
// Top level of the deadline task scheduler: sequencer, valid bits and result word.
// Depends on dts_pkg and dts_entry_ram.
//
//   Channel   Role    Handshake          Contents
//   s_*       input   s_tvalid/s_tready  operation, time, task id, delay, period
//   m_*       output  m_tvalid/m_tready  fired flag, full flag, fired task id
//
// A tick word reads the task memory one slot per cycle in ST_SCAN, then passes
// ST_DRAIN, ST_UPDATE and ST_RESULT before s_tready rises again.
// A schedule word walks the valid bits to the lowest free slot in ST_SCAN.
// An undefined operation goes straight from ST_IDLE to ST_RESULT.
// Reset clears every valid bit at once; no clearing pass is needed.
// The result register holds a word while m_tready is low; the next input
// word is taken meanwhile, and only its own result waits for the register.

module deadline_task_scheduler
  import dts_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] now_ms, [39:32] task_id, [71:40] start_delay, [103:72] period
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [1:0] operation
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] fired_task_id
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [0] fired, [1] table_full
  output logic [OUT_USER_W-1:0] m_tuser
);

  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

  state_t state, state_next;

  // Captured input word.
  op_t         op_r;
  logic [31:0] now_r;
  logic [7:0]  id_r;
  logic [31:0] first_r;
  logic [31:0] period_r;

  // Scan state.
  logic [SLOT_W-1:0]      cnt;
  logic [TABLE_DEPTH-1:0] valid;
  logic                   rd_pend;
  logic [SLOT_W-1:0]      rd_slot;
  logic                   have_best;
  entry_t                 best;
  logic [SLOT_W-1:0]      best_slot;

  // Result being built.
  logic       res_fired;
  logic [7:0] res_id;
  logic       res_full;

  // Memory port signals.
  logic              ram_rd_en;
  logic              ram_wr_en;
  logic [SLOT_W-1:0] ram_wr_addr;
  entry_t            ram_wr_data;
  entry_t            ram_rd_data;

  // Decoded conditions.
  logic in_acc;
  logic is_tick;
  logic cnt_last;
  logic slot_free;
  logic fire;
  logic take_best;
  logic out_load;

  assign in_acc    = s_tvalid && s_tready;
  assign is_tick   = (op_r == OP_TICK);
  assign cnt_last  = (cnt == LAST_SLOT);
  assign slot_free = !valid[cnt];
  assign fire      = have_best && has_elapsed(best.deadline, now_r);
  assign take_best = rd_pend && (!have_best || is_earlier(ram_rd_data.deadline, best.deadline));

  dts_entry_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (cnt),
    .rd_data (ram_rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (op_t'(s_tuser))
            OP_TICK, OP_ONE_SHOT, OP_PERIODIC: state_next = ST_SCAN;
            default:                           state_next = ST_RESULT;
          endcase
        end
      end
      ST_SCAN: begin
        if (is_tick) begin
          if (cnt_last) begin
            state_next = ST_DRAIN;
          end
        end else if (slot_free || cnt_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_DRAIN:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_RESULT;
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory controls for each state.
  always_comb begin
    s_tready    = (state == ST_IDLE);
    ram_rd_en   = (state == ST_SCAN) && is_tick;
    ram_wr_en   = 1'b0;
    ram_wr_addr = cnt;
    ram_wr_data = '{id: id_r, one_shot: (op_r == OP_ONE_SHOT),
                    period: (op_r == OP_ONE_SHOT) ? 32'd0 : period_r,
                    deadline: now_r + first_r};
    out_load    = 1'b0;
    unique case (state)
      ST_SCAN: begin
        ram_wr_en = !is_tick && slot_free;
      end
      ST_UPDATE: begin
        // Re-arm a periodic winner in place.
        ram_wr_en   = fire && !best.one_shot;
        ram_wr_addr = best_slot;
        ram_wr_data = '{id: best.id, one_shot: best.one_shot, period: best.period,
                        deadline: now_r + best.period};
      end
      ST_RESULT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  // Control state: sequencer, valid bits, scan bookkeeping and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      have_best <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN) && is_tick && valid[cnt];
      if (in_acc) begin
        cnt       <= '0;
        have_best <= 1'b0;
      end else if (state == ST_SCAN && !cnt_last) begin
        cnt <= cnt + SLOT_W'(1);
      end
      if (take_best) begin
        have_best <= 1'b1;
      end
      // A schedule claims the lowest free slot.
      if (state == ST_SCAN && !is_tick && slot_free) begin
        valid[cnt] <= 1'b1;
      end
      // A fired one-shot task leaves the table.
      if (state == ST_UPDATE && fire && best.one_shot) begin
        valid[best_slot] <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: captured word, best candidate, result and output word.
  always_ff @(posedge clk) begin
    rd_slot <= cnt;
    if (in_acc) begin
      op_r      <= op_t'(s_tuser);
      now_r     <= s_tdata[31:0];
      id_r      <= s_tdata[39:32];
      first_r   <= s_tdata[71:40];
      period_r  <= s_tdata[103:72];
      res_fired <= 1'b0;
      res_id    <= 8'd0;
      res_full  <= 1'b0;
    end
    if (take_best) begin
      best      <= ram_rd_data;
      best_slot <= rd_slot;
    end
    if (state == ST_SCAN && !is_tick && !slot_free && cnt_last) begin
      res_full <= 1'b1;
    end
    if (state == ST_UPDATE && fire) begin
      res_fired <= 1'b1;
      res_id    <= best.id;
    end
    if (out_load) begin
      m_tdata <= res_id;
      m_tuser <= {res_full, res_fired};
    end
  end

`ifndef SYNTHESIS
  // The sequencer never reads and writes the task memory in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(ram_wr_en && ram_rd_en))
    else $error("task memory read and write overlap");

  // A schedule that finds a free slot leaves that slot marked valid.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !is_tick && slot_free) |=> valid[$past(cnt)])
    else $error("scheduled slot not marked valid");

  // A fired one-shot task is gone from the table afterwards.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && fire && best.one_shot) |=> !valid[$past(best_slot)])
    else $error("one-shot task still valid after firing");

  // A result never reports both a firing and a full table, and an idle id is zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!(m_tuser[0] && m_tuser[1]) && (m_tuser[0] || (m_tdata == '0))))
    else $error("inconsistent result word");
`endif

endmodule

/* test/scheduler_checker.sv */
`timescale 1ns / 100ps
// Checker for the deadline task scheduler: follows both stream channels, keeps its own
// copy of the task table and compares every result word with the predicted one.
// Depends on dts_pkg for the stream widths, operation codes and the entry layout.

module scheduler_checker
  import dts_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [OUT_USER_W-1:0] m_tuser,
  output int                    mismatches,
  output int                    outstanding
);

  // One result word as the scheduler should produce it.
  typedef struct packed {
    logic       fired;
    logic [7:0] task_id;
    logic       full;
  } outcome_t;

  // Shadow copy of the task table.
  logic     slot_busy [TABLE_DEPTH];
  entry_t   slot_entry [TABLE_DEPTH];

  // Outcomes of accepted words whose result word has not yet been taken.
  outcome_t awaited_outcomes [$];

  // A deadline counts as passed up to half the range behind, and a little
  // beyond half the range ahead as well.
  function automatic logic deadline_passed(input logic [31:0] deadline,
                                           input logic [31:0] now);
    if (now >= deadline) return (now - deadline) <= HALF_RANGE;
    return (deadline - now) >= HALF_RANGE;
  endfunction

  // The candidate is sooner when the best lies ahead of it by less than half
  // the range; equal deadlines leave the lower slot in place.
  function automatic logic sooner(input logic [31:0] cand, input logic [31:0] best);
    logic [31:0] gap;
    gap = best - cand;
    return (gap != 32'd0) && !gap[31];
  endfunction

  // Applies one accepted word to the shadow table and returns its outcome.
  function automatic outcome_t apply_word(input logic [IN_USER_W-1:0] op,
                                          input logic [IN_DATA_W-1:0] data);
    logic [31:0] now;
    logic [7:0]  id;
    logic [31:0] delay;
    logic [31:0] per;
    int          pick;
    outcome_t    res;
    now   = data[31:0];
    id    = data[39:32];
    delay = data[71:40];
    per   = data[103:72];
    res   = '0;
    pick  = -1;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot_busy[i] &&
              (pick < 0 || sooner(slot_entry[i].deadline, slot_entry[pick].deadline)))
            pick = i;
        end
        if (pick >= 0 && deadline_passed(slot_entry[pick].deadline, now)) begin
          res.fired   = 1'b1;
          res.task_id = slot_entry[pick].id;
          if (slot_entry[pick].one_shot) begin
            slot_busy[pick] = 1'b0;
          end else begin
            slot_entry[pick].deadline = now + slot_entry[pick].period;
          end
        end
      end
      OP_ONE_SHOT, OP_PERIODIC: begin
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
          if (!slot_busy[i]) pick = i;
        end
        if (pick < 0) begin
          res.full = 1'b1;
        end else begin
          slot_busy[pick]           = 1'b1;
          slot_entry[pick].id       = id;
          slot_entry[pick].one_shot = (op == OP_ONE_SHOT);
          slot_entry[pick].period   = (op == OP_ONE_SHOT) ? 32'd0 : per;
          slot_entry[pick].deadline = now + delay;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Results are compared before the new input word is applied; a word's own
  // result can never leave on the edge that accepts it.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_busy[i] = 1'b0;
      awaited_outcomes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.fired   = m_tuser[0];
        got.task_id = m_tdata[7:0];
        got.full    = m_tuser[1];
        if (awaited_outcomes.size() == 0) begin
          $error("result word with no outstanding input word: fired %0d id %0d full %0d",
                 got.fired, got.task_id, got.full);
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.fired !== want.fired) begin
            $error("fired: expected %0d, actual %0d", want.fired, got.fired);
            mismatches++;
          end
          if (got.task_id !== want.task_id) begin
            $error("fired_task_id: expected %0d, actual %0d", want.task_id, got.task_id);
            mismatches++;
          end
          if (got.full !== want.full) begin
            $error("table_full: expected %0d, actual %0d", want.full, got.full);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) awaited_outcomes.push_back(apply_word(s_tuser, s_tdata));
    end
    outstanding = awaited_outcomes.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Top of the deadline task scheduler bench: clock, reset, stimulus and the verdict.
// Depends on dts_pkg, deadline_task_scheduler and scheduler_checker.

module testbench
  import dts_pkg::*;
();

  localparam int         TABLE_DEPTH = 16;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         TOTAL_WORDS = 1520;
  localparam int         HOLD_CYCLES = 400;

  // Pacing of the two sides over the run.
  typedef enum logic [1:0] {
    PACE_RX_SLOW,
    PACE_TX_SLOW,
    PACE_STEADY
  } pace_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [IN_USER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  int          mismatches;
  int          outstanding;
  pace_t       pace          = PACE_RX_SLOW;
  int          tx_idle_pct   = 34;
  int          rx_idle_pct   = 68;
  int          words_sent    = 0;
  int          periodic_left = 10;
  logic [31:0] clock_ms      = '0;

  deadline_task_scheduler #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  scheduler_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one word after a random number of idle cycles and waits until it is taken.
  task automatic send_word(input logic [1:0] op, input logic [31:0] at_ms,
                           input logic [7:0] id, input logic [31:0] delay,
                           input logic [31:0] per);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {per, delay, id, at_ms};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // Schedules a task with mostly short delays and periods, now and then one
  // at a full random value, right at the half-range boundary or just short of wrap.
  task automatic random_schedule(input logic [1:0] op);
    logic [31:0] at_ms;
    logic [31:0] delay;
    logic [31:0] per;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 70)      delay = $urandom_range(0, 30);
    else if (r < 85) delay = $urandom_range(31, 5000);
    else if (r < 93) delay = $urandom();
    else if (r < 97) delay = 32'h7FFF_FFFE + $urandom_range(0, 4);
    else             delay = 32'hFFFF_FFFF - $urandom_range(0, 1);
    r = $urandom_range(0, 99);
    if (r < 15)      per = 32'd0;
    else if (r < 80) per = $urandom_range(1, 60);
    else             per = $urandom();
    at_ms = ($urandom_range(0, 9) == 0) ? $urandom() : clock_ms;
    send_word(op, at_ms, 8'($urandom_range(0, 255)), delay, per);
  endtask

  // Receiver: random back-pressure, with one long hold-off when the steady
  // phase begins so that the result register and then the input stall.
  initial begin
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (pace == PACE_STEADY && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, reserved operation, the half-range
    // boundaries, a wrapped deadline, ties, re-arming and a zero period.
    send_word(OP_TICK, 32'd0, 8'hFF, '1, '1);
    send_word(OP_UNUSED, '1, '1, '1, '1);
    send_word(OP_ONE_SHOT, 32'd0, 8'hFF, 32'h8000_0000, '1);
    send_word(OP_TICK, 32'd0, 8'h00, '0, '0);
    send_word(OP_ONE_SHOT, 32'd0, 8'h11, 32'h7FFF_FFFF, '0);
    send_word(OP_TICK, 32'd0, 8'h00, '0, '0);
    send_word(OP_ONE_SHOT, 32'd0, 8'h22, 32'h7FFF_FFFE, '0);
    send_word(OP_TICK, 32'd0, 8'h00, '0, '0);
    send_word(OP_TICK, 32'h7FFF_FFFE, 8'h00, '0, '0);
    send_word(OP_ONE_SHOT, 32'h0000_0010, 8'h33, 32'hFFFF_FFFF, '0);
    send_word(OP_TICK, 32'h0000_0010, 8'h00, '0, '0);
    send_word(OP_PERIODIC, 32'h0000_0100, 8'h01, 32'd0, 32'h0000_1000);
    send_word(OP_ONE_SHOT, 32'h0000_0100, 8'h02, 32'd0, '0);
    send_word(OP_TICK, 32'h0000_0100, 8'h00, '0, '0);
    send_word(OP_TICK, 32'h0000_0100, 8'h00, '0, '0);
    send_word(OP_PERIODIC, 32'h0000_0200, 8'h80, 32'd5, 32'd0);
    send_word(OP_TICK, 32'h0000_0205, 8'h00, '0, '0);
    clock_ms = 32'h0000_0205;

    // Random part: mostly ticks on a slowly advancing clock and short-lived
    // one-shot tasks, a few periodic ones, reserved words and table-filling bursts.
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent >= 2 * TOTAL_WORDS / 3 && pace != PACE_STEADY) begin
        pace        <= PACE_STEADY;
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end else if (words_sent >= TOTAL_WORDS / 3 && pace == PACE_RX_SLOW) begin
        pace        <= PACE_TX_SLOW;
        tx_idle_pct <= 68;
        rx_idle_pct <= 34;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        r = $urandom_range(0, 99);
        if (r < 80)      clock_ms += $urandom_range(0, 6);
        else if (r < 92) clock_ms += $urandom_range(7, 300);
        else if (r < 97) clock_ms = $urandom();
        else             clock_ms += 32'h7FFF_FFFE + $urandom_range(0, 4);
        send_word(OP_TICK, clock_ms, 8'($urandom_range(0, 255)), $urandom(), $urandom());
      end else if (r < 94) begin
        // Periodic tasks never leave the table, so they are kept scarce
        // until the closing stretch.
        if ((periodic_left > 0 && $urandom_range(0, 39) == 0) ||
            (words_sent > TOTAL_WORDS - 200 && $urandom_range(0, 3) == 0)) begin
          periodic_left--;
          random_schedule(OP_PERIODIC);
        end else begin
          random_schedule(OP_ONE_SHOT);
        end
      end else if (r < 99) begin
        send_word(OP_UNUSED, $urandom(), 8'($urandom_range(0, 255)), $urandom(), $urandom());
      end else begin
        repeat ($urandom_range(TABLE_DEPTH, TABLE_DEPTH + 4)) random_schedule(OP_ONE_SHOT);
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for the last result, then a little longer for strays.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * TABLE_DEPTH) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("deadline_task_scheduler verification clean");
    end else begin
      $display("deadline_task_scheduler verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run.
  initial begin
    #5_000_000;
    $display("deadline_task_scheduler verification failed");
    $finish;
  end

endmodule

/* files.f */
src/dts_pkg.sv
src/dts_entry_ram.sv
src/deadline_task_scheduler.sv
test/scheduler_checker.sv
test/testbench.sv
